@@ sv/size_budget_min_eviction_table_unit_assert.svh @@
// ---------------------------------------------------------------------------
// size budget eviction table assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ---------------------------------------------------------------------------
`ifndef SIZE_BUDGET_MIN_EVICTION_TABLE_UNIT_ASSERT_SVH
`define SIZE_BUDGET_MIN_EVICTION_TABLE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SBMET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBMET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sbmet_pkg.sv @@
// ---------------------------------------------------------------------------
// sbmet_pkg
// types and constants shared by the size budget eviction table modules
// ---------------------------------------------------------------------------
package sbmet_pkg;

    localparam int SIZE_W        = 20;
    localparam int DATE_W        = 32;
    localparam int TOTAL_W       = 25;
    localparam int SUM_W         = TOTAL_W + 1;
    localparam int RES_COUNT_W   = 6;
    localparam int ENTRY_W       = SIZE_W + DATE_W;
    localparam int MAX_RESULTS   = 32;
    localparam int EVICT_CNT_W   = 6;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [TOTAL_W-1:0] SIZE_BUDGET_RESET = TOTAL_W'(32 * 1024);

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TRIM = 1'b1;

    // word index of the size budget register
    localparam logic [APB_ADDR_W-3:0] REG_SIZE_BUDGET = '0;

    typedef enum logic [1:0] {
        STAT_ADDED    = 2'd0,
        STAT_REJECTED = 2'd1,
        STAT_EVICTED  = 2'd2,
        STAT_NONE     = 2'd3
    } t_status;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] file_size;
        logic [DATE_W-1:0] file_date;
    } t_item;

    typedef struct packed {
        t_status                status;
        logic [SIZE_W-1:0]      evicted_size;
        logic [DATE_W-1:0]      evicted_date;
        logic [RES_COUNT_W-1:0] entry_count;
        logic [TOTAL_W-1:0]     size_total;
        logic                   last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_EVICT
    } t_state;

    typedef struct packed {
        logic accept_add;
        logic accept_trim;
        logic add_try;
        logic scan_issue;
        logic evict;
    } t_dp_cmd;

    typedef struct packed {
        logic add_reject;
        logic over_budget;
        logic slot_free;
        logic scan_end;
        logic best_found;
        logic evict_last;
    } t_dp_stat;

endpackage

@@ sv/sbmet_ram.sv @@
// ---------------------------------------------------------------------------
// sbmet_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module sbmet_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sbmet_ctrl.sv @@
// ---------------------------------------------------------------------------
// sbmet_ctrl
// sequencer for add slot search and the per-eviction minimum scan
// ---------------------------------------------------------------------------
`include "size_budget_min_eviction_table_unit_assert.svh"

module sbmet_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_func,
    input  sbmet_pkg::t_dp_stat i_stat,
    output sbmet_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    sbmet_pkg::t_state r_state;
    sbmet_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbmet_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbmet_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_func == sbmet_pkg::FUNC_ADD) begin
                        if (!i_stat.add_reject) begin
                            n_state = sbmet_pkg::ST_ADD_SCAN;
                        end
                    end else if (i_stat.over_budget) begin
                        n_state = sbmet_pkg::ST_SCAN;
                    end
                end
            end
            sbmet_pkg::ST_ADD_SCAN: begin
                if (i_stat.slot_free) begin
                    n_state = sbmet_pkg::ST_IDLE;
                end
            end
            sbmet_pkg::ST_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = sbmet_pkg::ST_SCAN_TAIL;
                end
            end
            sbmet_pkg::ST_SCAN_TAIL: begin
                n_state = sbmet_pkg::ST_EVICT;
            end
            sbmet_pkg::ST_EVICT: begin
                if (!i_stat.best_found || i_stat.evict_last) begin
                    n_state = sbmet_pkg::ST_IDLE;
                end else begin
                    n_state = sbmet_pkg::ST_SCAN;
                end
            end
            default: begin
                n_state = sbmet_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            sbmet_pkg::ST_IDLE: begin
                o_busy            = 1'b0;
                o_cmd.accept_add  = i_start && (i_func == sbmet_pkg::FUNC_ADD);
                o_cmd.accept_trim = i_start && (i_func == sbmet_pkg::FUNC_TRIM);
            end
            sbmet_pkg::ST_ADD_SCAN: begin
                o_cmd.add_try = 1'b1;
            end
            sbmet_pkg::ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
            end
            sbmet_pkg::ST_SCAN_TAIL: begin
                o_cmd = '0;
            end
            sbmet_pkg::ST_EVICT: begin
                o_cmd.evict = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `SBMET_ASSERT_NOW(a_accept_only_idle, o_busy, !(o_cmd.accept_add || o_cmd.accept_trim), "item accepted while busy")
    `SBMET_ASSERT_NEXT(a_scan_follows_evict, (r_state == sbmet_pkg::ST_EVICT) && i_stat.best_found && !i_stat.evict_last, r_state == sbmet_pkg::ST_SCAN, "eviction loop did not rescan")

endmodule

@@ sv/sbmet_dp.sv @@
// ---------------------------------------------------------------------------
// sbmet_dp
// entry memory, valid bits, count and total, minimum tracker, result register
// ---------------------------------------------------------------------------
`include "size_budget_min_eviction_table_unit_assert.svh"

module sbmet_dp #(
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbmet_pkg::t_dp_cmd                i_cmd,
    output sbmet_pkg::t_dp_stat               o_stat,
    input  sbmet_pkg::t_item                  i_item,
    input  logic [sbmet_pkg::TOTAL_W-1:0]     i_budget,
    output sbmet_pkg::t_result                o_result,
    output logic                              o_result_valid
);

    localparam int IdxW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    // control state
    logic [DEPTH-1:0]                   r_valid, n_valid;
    logic [CntW-1:0]                    r_count, n_count;
    logic [sbmet_pkg::TOTAL_W-1:0]      r_total, n_total;
    logic [IdxW-1:0]                    r_idx, n_idx;
    logic                               r_pend, n_pend;
    logic                               r_found, n_found;
    logic [sbmet_pkg::EVICT_CNT_W-1:0]  r_n, n_n;
    logic                               r_out_valid, n_out_valid;

    // payload
    logic [IdxW-1:0]                    r_pend_idx, n_pend_idx;
    logic [IdxW-1:0]                    r_best_idx, n_best_idx;
    logic [sbmet_pkg::ENTRY_W-1:0]      r_best, n_best;
    sbmet_pkg::t_item                   r_item, n_item;
    sbmet_pkg::t_result                 r_out, n_out;

    logic [sbmet_pkg::ENTRY_W-1:0]      rd_entry;
    logic [sbmet_pkg::SUM_W-1:0]        add_sum;
    logic [sbmet_pkg::SIZE_W-1:0]       best_size;
    logic [sbmet_pkg::DATE_W-1:0]       best_date;
    logic [sbmet_pkg::TOTAL_W-1:0]      ev_total;
    logic [CntW-1:0]                    ev_count;
    logic                               scan_end;
    logic [IdxW-1:0]                    idx_inc;
    logic                               ram_we;

    sbmet_ram #(
        .WIDTH (sbmet_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({r_item.file_size, r_item.file_date}),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    assign ram_we    = i_cmd.add_try && !r_valid[r_idx];
    assign scan_end  = (r_idx == IdxW'(DEPTH - 1));
    assign idx_inc   = scan_end ? '0 : r_idx + 1'b1;
    assign add_sum   = {1'b0, r_total} + sbmet_pkg::SUM_W'(i_item.file_size);
    assign best_size = r_best[sbmet_pkg::ENTRY_W-1:sbmet_pkg::DATE_W];
    assign best_date = r_best[sbmet_pkg::DATE_W-1:0];
    assign ev_total  = (r_total >= sbmet_pkg::TOTAL_W'(best_size))
                     ? r_total - sbmet_pkg::TOTAL_W'(best_size) : '0;
    assign ev_count  = (r_count != '0) ? r_count - 1'b1 : '0;

    always_comb begin
        o_stat             = '0;
        o_stat.add_reject  = (r_count == CntW'(DEPTH)) || add_sum[sbmet_pkg::SUM_W-1];
        o_stat.over_budget = r_total > i_budget;
        o_stat.slot_free   = !r_valid[r_idx];
        o_stat.scan_end    = scan_end;
        o_stat.best_found  = r_found;
        o_stat.evict_last  = (ev_total <= i_budget) || (ev_count == '0)
                           || (r_n == sbmet_pkg::EVICT_CNT_W'(sbmet_pkg::MAX_RESULTS - 1));
    end

    always_comb begin
        n_valid     = r_valid;
        n_count     = r_count;
        n_total     = r_total;
        n_idx       = r_idx;
        n_pend      = i_cmd.scan_issue;
        n_pend_idx  = r_idx;
        n_found     = r_found;
        n_n         = r_n;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_item      = r_item;
        n_out_valid = 1'b0;
        n_out       = r_out;

        // running minimum over {size, date}; strict compare keeps the lowest slot
        if (r_pend && r_valid[r_pend_idx] && (!r_found || (rd_entry < r_best))) begin
            n_found    = 1'b1;
            n_best     = rd_entry;
            n_best_idx = r_pend_idx;
        end

        if (i_cmd.accept_add) begin
            n_item = i_item;
            n_idx  = '0;
            if (o_stat.add_reject) begin
                n_out_valid       = 1'b1;
                n_out             = '0;
                n_out.status      = sbmet_pkg::STAT_REJECTED;
                n_out.entry_count = sbmet_pkg::RES_COUNT_W'(r_count);
                n_out.size_total  = r_total;
                n_out.last        = 1'b1;
            end
        end

        if (i_cmd.accept_trim) begin
            n_idx   = '0;
            n_found = 1'b0;
            n_n     = '0;
            if (!o_stat.over_budget) begin
                n_out_valid       = 1'b1;
                n_out             = '0;
                n_out.status      = sbmet_pkg::STAT_NONE;
                n_out.entry_count = sbmet_pkg::RES_COUNT_W'(r_count);
                n_out.size_total  = r_total;
                n_out.last        = 1'b1;
            end
        end

        if (i_cmd.add_try) begin
            if (!r_valid[r_idx]) begin
                n_valid[r_idx]    = 1'b1;
                n_count           = r_count + 1'b1;
                n_total           = r_total + sbmet_pkg::TOTAL_W'(r_item.file_size);
                n_out_valid       = 1'b1;
                n_out             = '0;
                n_out.status      = sbmet_pkg::STAT_ADDED;
                n_out.entry_count = sbmet_pkg::RES_COUNT_W'(n_count);
                n_out.size_total  = n_total;
                n_out.last        = 1'b1;
            end else begin
                n_idx = idx_inc;
            end
        end

        if (i_cmd.scan_issue) begin
            n_idx = idx_inc;
        end

        if (i_cmd.evict) begin
            n_idx   = '0;
            n_found = 1'b0;
            if (r_found) begin
                n_valid[r_best_idx] = 1'b0;
                n_count             = ev_count;
                n_total             = ev_total;
                n_n                 = r_n + 1'b1;
                n_out_valid         = 1'b1;
                n_out.status        = sbmet_pkg::STAT_EVICTED;
                n_out.evicted_size  = best_size;
                n_out.evicted_date  = best_date;
                n_out.entry_count   = sbmet_pkg::RES_COUNT_W'(ev_count);
                n_out.size_total    = ev_total;
                n_out.last          = o_stat.evict_last;
            end else if (r_n == '0) begin
                n_out_valid       = 1'b1;
                n_out             = '0;
                n_out.status      = sbmet_pkg::STAT_NONE;
                n_out.entry_count = sbmet_pkg::RES_COUNT_W'(r_count);
                n_out.size_total  = r_total;
                n_out.last        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_total     <= n_total;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_item     <= n_item;
        r_out      <= n_out;
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

    `SBMET_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CntW'(DEPTH), "entry count above depth")
    `SBMET_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(r_valid) == 32'(r_count), "entry count differs from valid bits")
    `SBMET_ASSERT_NOW(a_evict_valid_slot, i_cmd.evict && r_found, r_valid[r_best_idx], "evicting a free slot")
    `SBMET_ASSERT_NOW(a_add_slot_free, ram_we, r_count < CntW'(DEPTH), "entry written into a full table")

endmodule

@@ sv/size_budget_min_eviction_table_unit.sv @@
// add: reject is strobed in the cycle after start; an accepted add searches for a free slot and
//   strobes its result once it finds one (one valid bit checked per cycle)
// trim: each eviction scans all DEPTH entries through the entry ram and then strobes its
//   result; the scan repeats after each eviction, up to 32 results;
//   an item under budget answers in the cycle after start
// results are strobed for one cycle and cannot be stalled; busy is high until the item ends
// reset clears valid bits, count and total, and sets size_budget to 32768; no clearing pass
// ---------------------------------------------------------------------------
// size_budget_min_eviction_table_unit
// size/date entry table with budget trim by smallest-size, oldest-date eviction
// ---------------------------------------------------------------------------
module size_budget_min_eviction_table_unit #(
    parameter int DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sbmet_pkg::t_item                    i_item,
    output sbmet_pkg::t_result                  o_result,
    output logic                                o_result_valid,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sbmet_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sbmet_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sbmet_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic [sbmet_pkg::TOTAL_W-1:0] r_size_budget;
    logic                          budget_sel;
    sbmet_pkg::t_dp_cmd            dp_cmd;
    sbmet_pkg::t_dp_stat           dp_stat;

    assign pready     = 1'b1;
    assign budget_sel = (paddr[sbmet_pkg::APB_ADDR_W-1:2] == sbmet_pkg::REG_SIZE_BUDGET);
    assign prdata     = budget_sel ? sbmet_pkg::APB_DATA_W'(r_size_budget) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_budget <= sbmet_pkg::SIZE_BUDGET_RESET;
        end else if (psel && penable && pwrite && pready && budget_sel) begin
            r_size_budget <= pwdata[sbmet_pkg::TOTAL_W-1:0];
        end
    end

    sbmet_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    sbmet_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_item         (i_item),
        .i_budget       (r_size_budget),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

@@ verif/sbmet_table_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbmet_table_checker
// mirrors the size/date entry table of the eviction unit, works out the
// results of every accepted item and compares them with the result strobes
// ---------------------------------------------------------------------------
module sbmet_table_checker
    import sbmet_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_item                 i_item,
    input  t_result               i_result,
    input  logic                  i_result_valid,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic [APB_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [TOTAL_W-1:0]    TOTAL_MAX   = '1;
    localparam logic [APB_ADDR_W-1:0] BUDGET_ADDR = {REG_SIZE_BUDGET, 2'b00};

    logic [SIZE_W-1:0]      slot_size [DEPTH];
    logic [DATE_W-1:0]      slot_date [DEPTH];
    logic                   slot_used [DEPTH];
    logic [RES_COUNT_W-1:0] used_count = '0;
    logic [TOTAL_W-1:0]     size_sum = '0;
    logic [TOTAL_W-1:0]     budget = SIZE_BUDGET_RESET;

    t_result table_outcomes_q[$];
    int      fail_count = 0;
    int      pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // result as the unit reports it, with count and total taken after the change
    function automatic t_result table_result(input t_status st,
                                             input logic [SIZE_W-1:0] sz,
                                             input logic [DATE_W-1:0] dt,
                                             input logic lst);
        t_result r;
        r.status       = st;
        r.evicted_size = sz;
        r.evicted_date = dt;
        r.entry_count  = used_count;
        r.size_total   = size_sum;
        r.last         = lst;
        return r;
    endfunction

    task automatic apply_table_item(input t_item it);
        int      free_slot;
        int      best;
        int      n;
        int      i;
        t_result held;
        free_slot = -1;
        n = 0;
        held = '0;
        if (it.func == FUNC_ADD) begin
            for (i = DEPTH - 1; i >= 0; i--) begin
                if (!slot_used[i]) free_slot = i;
            end
            if (free_slot < 0 ||
                ({1'b0, size_sum} + SUM_W'(it.file_size)) > {1'b0, TOTAL_MAX}) begin
                table_outcomes_q.push_back(table_result(STAT_REJECTED, '0, '0, 1'b1));
            end else begin
                slot_size[free_slot] = it.file_size;
                slot_date[free_slot] = it.file_date;
                slot_used[free_slot] = 1'b1;
                used_count = used_count + 1'b1;
                size_sum = size_sum + TOTAL_W'(it.file_size);
                table_outcomes_q.push_back(table_result(STAT_ADDED, '0, '0, 1'b1));
            end
        end else begin
            while (size_sum > budget && n < MAX_RESULTS) begin
                best = -1;
                // smallest size wins, oldest date breaks ties, lowest slot after that
                for (i = 0; i < DEPTH; i++) begin
                    if (slot_used[i]) begin
                        if (best < 0 || slot_size[i] < slot_size[best] ||
                            (slot_size[i] == slot_size[best] &&
                             slot_date[i] < slot_date[best]))
                            best = i;
                    end
                end
                if (best < 0) break;
                slot_used[best] = 1'b0;
                if (used_count != 0) used_count = used_count - 1'b1;
                size_sum = (size_sum >= TOTAL_W'(slot_size[best])) ?
                           size_sum - TOTAL_W'(slot_size[best]) : '0;
                if (n > 0) table_outcomes_q.push_back(held);
                held = table_result(STAT_EVICTED, slot_size[best], slot_date[best], 1'b0);
                n++;
            end
            if (n == 0) begin
                table_outcomes_q.push_back(table_result(STAT_NONE, '0, '0, 1'b1));
            end else begin
                held.last = 1'b1;
                table_outcomes_q.push_back(held);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        logic    bad;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) slot_used[k] = 1'b0;
            used_count = '0;
            size_sum = '0;
            budget = SIZE_BUDGET_RESET;
            table_outcomes_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == BUDGET_ADDR) budget = i_pwdata[TOTAL_W-1:0];
                end else if (i_paddr == BUDGET_ADDR &&
                             i_prdata !== APB_DATA_W'(budget)) begin
                    $display("%0t: size_budget read expected %0d, got %0d",
                             $time, budget, i_prdata);
                    fail_count++;
                end
            end
            if (i_result_valid) begin
                if (table_outcomes_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got %p", $time, i_result);
                    fail_count++;
                end else begin
                    want = table_outcomes_q.pop_front();
                    bad = 1'b0;
                    if (i_result.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_result.status);
                        bad = 1'b1;
                    end
                    if (i_result.evicted_size !== want.evicted_size) begin
                        $display("%0t: evicted_size expected %0d, got %0d",
                                 $time, want.evicted_size, i_result.evicted_size);
                        bad = 1'b1;
                    end
                    if (i_result.evicted_date !== want.evicted_date) begin
                        $display("%0t: evicted_date expected %0h, got %0h",
                                 $time, want.evicted_date, i_result.evicted_date);
                        bad = 1'b1;
                    end
                    if (i_result.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, want.entry_count, i_result.entry_count);
                        bad = 1'b1;
                    end
                    if (i_result.size_total !== want.size_total) begin
                        $display("%0t: size_total expected %0d, got %0d",
                                 $time, want.size_total, i_result.size_total);
                        bad = 1'b1;
                    end
                    if (i_result.last !== want.last) begin
                        $display("%0t: last expected %0b, got %0b",
                                 $time, want.last, i_result.last);
                        bad = 1'b1;
                    end
                    if (bad) fail_count++;
                end
            end
            // a new item can be taken on the edge that ends the previous one
            if (i_start && !i_busy) apply_table_item(i_item);
        end
        pending_count = table_outcomes_q.size();
    end

endmodule

@@ verif/size_budget_min_eviction_table_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// size_budget_min_eviction_table_unit_tb
// drives add and trim items in random bursts under a range of size budgets,
// from directed corner cases to random fill and trim phases; the table
// checker beside the unit predicts and compares every result
// ---------------------------------------------------------------------------
module size_budget_min_eviction_table_unit_tb;
    import sbmet_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_LIMIT   = 2000;

    localparam logic [TOTAL_W-1:0]    BUDGET_MAX  = '1;
    localparam logic [APB_ADDR_W-1:0] BUDGET_ADDR = {REG_SIZE_BUDGET, 2'b00};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_item                 i_item = '0;
    t_result               o_result;
    logic                  o_result_valid;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int burst_left = 0;
    int items_sent = 0;

    always #10 i_clk = ~i_clk;

    size_budget_min_eviction_table_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sbmet_table_checker #(
        .DEPTH(DEPTH)
    ) u_table_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result       (o_result),
        .i_result_valid (o_result_valid),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // counts cycles in which nothing at all is accepted and no result is strobed
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_budget(input logic [TOTAL_W-1:0] value);
        apb_access(1'b1, BUDGET_ADDR, APB_DATA_W'(value));
        apb_access(1'b0, BUDGET_ADDR, '0);
    endtask

    // called just after a rising edge; returns on the edge that took the item, or after the gap that ends a burst
    task automatic send_item(input t_item it, input bit phase_end);
        int gap;
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        burst_left--;
        start  <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        items_sent++;
        // start stays high into the next item of the burst
        if (burst_left == 0 || phase_end) begin
            start <= 1'b0;
            burst_left = 0;
            if (!phase_end) begin
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 60)
                                                  : $urandom_range(1, 4);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    function automatic logic [SIZE_W-1:0] rand_size(input int mode);
        case (mode)
            0:       return SIZE_W'($urandom_range(0, 3));
            1:       return SIZE_W'($urandom_range(0, 255));
            2:       return $urandom_range(0, 1) ? '1 : '0;
            default: return SIZE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATE_W-1:0] rand_date(input int mode);
        if (mode == 0) return DATE_W'($urandom_range(0, 3));
        return $urandom;
    endfunction

    function automatic t_item trim_item();
        return t_item'{FUNC_TRIM, SIZE_W'($urandom), $urandom};
    endfunction

    initial begin
        int               target;
        int               kind;
        int               n_items;
        int               add_pct;
        int               size_mode;
        int               date_mode;
        bit               first_phase;
        logic [TOTAL_W-1:0] bval;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing to evict from an empty table, ignored fields all ones
        send_item(t_item'{FUNC_TRIM, 20'hFFFFF, 32'hFFFFFFFF}, 1'b0);
        send_item(t_item'{FUNC_ADD, 20'hFFFFF, 32'hFFFFFFFF}, 1'b0);
        send_item(t_item'{FUNC_ADD, 20'h00000, 32'h00000000}, 1'b0);
        send_item(t_item'{FUNC_ADD, 20'h00000, 32'hFFFFFFFF}, 1'b0);
        send_item(t_item'{FUNC_ADD, 20'hFFFFF, 32'h00000000}, 1'b0);
        // same size and date twice: lowest slot goes first
        send_item(t_item'{FUNC_ADD, 20'hFFFFF, 32'h00000000}, 1'b0);
        send_item(t_item'{FUNC_TRIM, 20'h00000, 32'h00000000}, 1'b1);
        wait_idle();

        // total lands exactly on the budget after one eviction
        send_item(t_item'{FUNC_ADD, 20'd16384, 32'd5}, 1'b0);
        send_item(t_item'{FUNC_ADD, 20'd16384, 32'd3}, 1'b0);
        send_item(t_item'{FUNC_ADD, 20'd1, 32'd7}, 1'b0);
        send_item(trim_item(), 1'b0);
        send_item(trim_item(), 1'b1);
        wait_idle();

        set_budget('0);
        send_item(trim_item(), 1'b1);
        wait_idle();
        set_budget(BUDGET_MAX);
        send_item(t_item'{FUNC_ADD, 20'hFFFFF, 32'd9}, 1'b0);
        send_item(trim_item(), 1'b1);
        wait_idle();

        target = items_sent + RANDOM_ITEMS;
        first_phase = 1'b1;
        while (items_sent < target) begin
            case ($urandom_range(0, 5))
                0:       bval = '0;
                1:       bval = BUDGET_MAX;
                2:       bval = SIZE_BUDGET_RESET;
                3:       bval = TOTAL_W'($urandom_range(0, 300));
                4:       bval = TOTAL_W'($urandom_range(0, 1 << 21));
                default: bval = TOTAL_W'($urandom);
            endcase
            set_budget(bval);
            size_mode = $urandom_range(0, 3);
            date_mode = $urandom_range(0, 1);
            // the first phase always sends more adds than the table holds
            kind = first_phase ? 1 : $urandom_range(0, 2);
            first_phase = 1'b0;
            if (kind == 1) begin
                n_items = DEPTH + $urandom_range(1, 4);
                for (int k = 0; k < n_items; k++)
                    send_item(t_item'{FUNC_ADD, rand_size(size_mode), rand_date(date_mode)},
                              1'b0);
                send_item(trim_item(), 1'b0);
                send_item(trim_item(), 1'b1);
            end else begin
                add_pct = $urandom_range(50, 90);
                n_items = $urandom_range(15, 50);
                for (int k = 0; k < n_items; k++) begin
                    if ($urandom_range(0, 99) < add_pct)
                        send_item(t_item'{FUNC_ADD, rand_size(size_mode), rand_date(date_mode)},
                                  k == n_items - 1);
                    else
                        send_item(trim_item(), k == n_items - 1);
                end
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
